>>> hdl/mass_pkg.sv
// Shared types, constants and helpers for the multi-axis startup sequencer.
package mass_pkg;

  // Axis geometry
  localparam int AxisCount = 4;
  localparam int ZIndex    = 2;
  localparam int XIndex    = 0;
  localparam int YawIndex  = 3;
  localparam int MaskWidth = 4;
  localparam int AxisLimit = (AxisCount < MaskWidth) ? AxisCount : MaskWidth;

  // Field widths
  localparam int TimeWidth    = 32;
  localparam int TimeoutWidth = 20;
  localparam int ModeWidth    = 2;
  localparam int AxisWidth    = 2;
  localparam int CmdWidth     = 3;
  localparam int KindWidth    = 2;
  localparam int PhaseWidth   = 3;
  localparam int ActWidth     = 2;
  localparam int InDataWidth  = 120;
  localparam int OutDataWidth = 16;

  // Incoming item codes
  typedef enum logic [CmdWidth-1:0] {
    CmdTick    = 3'd0,
    CmdInit    = 3'd1,
    CmdPrepare = 3'd2,
    CmdCancel  = 3'd3,
    CmdAccept  = 3'd4,
    CmdReject  = 3'd5
  } cmd_e;

  // Motor command kinds
  typedef enum logic [KindWidth-1:0] {
    KindEnable = 2'd0,
    KindOrigin = 2'd1,
    KindAction = 2'd2
  } kind_e;

  // Action modes
  localparam logic [ModeWidth-1:0] ModePress = 2'd0;
  localparam logic [ModeWidth-1:0] ModeRub   = 2'd1;
  localparam logic [ModeWidth-1:0] ModeSlide = 2'd2;

  // Action status codes
  localparam logic [ActWidth-1:0] ActDone = 2'd1;

  // Axis status bit positions
  localparam int StPending = 0;
  localparam int StEnReq   = 1;
  localparam int StReady   = 2;
  localparam int StOrigin  = 3;

  // Configuration register indexes
  localparam logic [1:0] CfgAutostartOn   = 2'd0;
  localparam logic [1:0] CfgAutostartMode = 2'd1;
  localparam logic [1:0] CfgSetupTimeout  = 2'd2;

  // Sequencer phases, one-hot
  typedef enum logic [7:0] {
    PhDisabled = 8'b0000_0001,
    PhWait     = 8'b0000_0010,
    PhEnable   = 8'b0000_0100,
    PhZero     = 8'b0000_1000,
    PhAction   = 8'b0001_0000,
    PhDone     = 8'b0010_0000,
    PhFailed   = 8'b0100_0000,
    PhStopped  = 8'b1000_0000
  } phase_e;

  // External phase code
  function automatic logic [PhaseWidth-1:0] phase_code(input phase_e ph);
    logic [PhaseWidth-1:0] code;
    unique case (ph)
      PhDisabled: code = 3'd0;
      PhWait:     code = 3'd1;
      PhEnable:   code = 3'd2;
      PhZero:     code = 3'd3;
      PhAction:   code = 3'd4;
      PhDone:     code = 3'd5;
      PhFailed:   code = 3'd6;
      PhStopped:  code = 3'd7;
      default:    code = 3'd0;
    endcase
    return code;
  endfunction

  // Mask bit of an axis index, empty when the axis does not take part
  function automatic logic [MaskWidth-1:0] axis_bit(input int idx);
    logic [MaskWidth-1:0] m;
    m = '0;
    if (idx >= 0 && idx < AxisLimit) begin
      m[idx] = 1'b1;
    end
    return m;
  endfunction

  // Result word fields
  typedef struct packed {
    logic                  busy;
    logic [PhaseWidth-1:0] phase;
    logic [ModeWidth-1:0]  cmd_mode;
    logic                  cmd_enable;
    logic [AxisWidth-1:0]  cmd_axis;
    logic [KindWidth-1:0]  cmd_kind;
    logic                  cmd_valid;
  } result_t;

endpackage

>>> hdl/multi_axis_startup_sequencer_unit.sv
// Multi-axis startup sequencer: input register, phase logic and result register.
// A word accepted into the input register moves on to the result register once that register
// is empty or its result is being taken, so its result comes out of the result register.
// Throughput: one word per cycle; while a result waits the input register takes one
// more word and then holds s_axis_tready low until the result is taken.
// Reset: rst_ni sets phase disabled, empties both registers, restores register defaults.
module multi_axis_startup_sequencer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [19:0]  cfg_wdata_i,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata from bit 0: now_ms(32) mode(2) fault_mask(4) healthy_mask(4) axis_status(4)
  // axis_flags_time(32) axis_position_time(32) axis_at_origin(1) action_status(2) pad
  input  logic [119:0] s_axis_tdata,
  // tuser: cmd(3)
  input  logic [2:0]   s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata from bit 0: cmd_valid(1) cmd_kind(2) cmd_axis(2) cmd_enable(1) cmd_mode(2)
  // phase(3) busy_res(1) pad
  output logic [15:0]  m_axis_tdata
);

  localparam int MW = mass_pkg::MaskWidth;
  localparam int TW = mass_pkg::TimeWidth;

  // Configuration registers
  logic                               autostart_on_q;
  logic [mass_pkg::ModeWidth-1:0]     autostart_mode_q;
  logic [mass_pkg::TimeoutWidth-1:0]  timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autostart_on_q   <= 1'b1;
      autostart_mode_q <= '0;
      timeout_q        <= 20'd2000;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mass_pkg::CfgAutostartOn) begin
        autostart_on_q <= cfg_wdata_i[0];
      end
      if (cfg_index_i == mass_pkg::CfgAutostartMode) begin
        autostart_mode_q <= cfg_wdata_i[1:0];
      end
      if (cfg_index_i == mass_pkg::CfgSetupTimeout) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Input register
  logic         in_valid_q;
  logic [119:0] in_data_q;
  logic [2:0]   in_cmd_q;
  logic         out_valid_q;
  logic         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Hold the payload while it waits
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_cmd_q  <= s_axis_tuser;
    end
  end

  // Unpack the held word
  logic [TW-1:0] now_ms, flags_t, pos_t;
  logic [1:0]    mode, act;
  logic [MW-1:0] faults, healthy, st;
  logic          at_origin;

  assign now_ms    = in_data_q[31:0];
  assign mode      = in_data_q[33:32];
  assign faults    = in_data_q[37:34];
  assign healthy   = in_data_q[41:38];
  assign st        = in_data_q[45:42];
  assign flags_t   = in_data_q[77:46];
  assign pos_t     = in_data_q[109:78];
  assign at_origin = in_data_q[110];
  assign act       = in_data_q[112:111];

  // Sequencer state
  mass_pkg::phase_e                phase_q, phase_d;
  logic [TW-1:0]                   phase_start_q, phase_start_d;
  logic [TW-1:0]                   accept_time_q, accept_time_d;
  logic                            sent_q, sent_d;
  logic                            prep_only_q, prep_only_d;
  logic [mass_pkg::ModeWidth-1:0]  run_mode_q, run_mode_d;
  logic [MW-1:0]                   axis_set_q, axis_set_d;
  logic [mass_pkg::AxisWidth-1:0]  cur_axis_q, cur_axis_d;
  mass_pkg::result_t               res_q, res_d;

  // Freshness and timeout tests
  logic [TW-1:0] flags_diff, pos_diff, elapsed;
  logic          flags_fresh, pos_fresh, timed_out;

  assign flags_diff  = flags_t - accept_time_q;
  assign pos_diff    = pos_t - accept_time_q;
  assign flags_fresh = (flags_diff != '0) && !flags_diff[TW-1];
  assign pos_fresh   = (pos_diff != '0) && !pos_diff[TW-1];
  assign elapsed     = now_ms - phase_start_q;
  assign timed_out   = elapsed >= {{(TW-mass_pkg::TimeoutWidth){1'b0}}, timeout_q};

  // Status bits of the current axis
  logic pending, en_req, ready, orig_ok, cur_healthy;
  assign pending     = st[mass_pkg::StPending];
  assign en_req      = st[mass_pkg::StEnReq];
  assign ready       = st[mass_pkg::StReady];
  assign orig_ok     = st[mass_pkg::StOrigin];
  assign cur_healthy = healthy[cur_axis_q];

  // Axis set and first axis of a new run
  logic [mass_pkg::ModeWidth-1:0] start_mode;
  logic [MW-1:0]                  start_set;
  logic [mass_pkg::AxisWidth-1:0] start_axis;

  always_comb begin
    start_mode = (in_cmd_q == mass_pkg::CmdInit) ? autostart_mode_q : mode;
    start_set  = mass_pkg::axis_bit(mass_pkg::ZIndex);
    if (start_mode == mass_pkg::ModeRub) begin
      start_set = start_set | mass_pkg::axis_bit(mass_pkg::YawIndex);
    end else if (start_mode == mass_pkg::ModeSlide) begin
      start_set = start_set | mass_pkg::axis_bit(mass_pkg::XIndex);
    end
    start_axis = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (start_set[i]) begin
        start_axis = mass_pkg::AxisWidth'(i);
      end
    end
  end

  // Next axis of the set above the current one
  logic                           nx_found;
  logic [mass_pkg::AxisWidth-1:0] nx_axis;

  always_comb begin
    nx_found = 1'b0;
    nx_axis  = '0;
    for (int i = MW - 1; i >= 0; i--) begin
      if (axis_set_q[i] && (i > int'(cur_axis_q))) begin
        nx_found = 1'b1;
        nx_axis  = mass_pkg::AxisWidth'(i);
      end
    end
  end

  // Phase logic for one word
  logic          run_busy, fail, zero_base, zero_quick, zero_full;
  logic [MW-1:0] allowed_down;

  assign run_busy = (phase_q == mass_pkg::PhWait) || (phase_q == mass_pkg::PhEnable) ||
                    (phase_q == mass_pkg::PhZero) || (phase_q == mass_pkg::PhAction);
  assign allowed_down = (phase_q == mass_pkg::PhZero) ? (MW'(1) << cur_axis_q) : '0;
  assign zero_base  = cur_healthy && !pending && orig_ok && en_req && ready;
  assign zero_quick = zero_base && prep_only_q && !sent_q;
  assign zero_full  = zero_base && pos_fresh && flags_fresh && at_origin;

  always_comb begin
    fail = 1'b0;
    if (phase_q != mass_pkg::PhAction && timed_out) begin
      fail = 1'b1;
    end
    if ((faults & axis_set_q) != '0) begin
      fail = 1'b1;
    end
    if (phase_q != mass_pkg::PhWait && ((~healthy & axis_set_q & ~allowed_down) != '0)) begin
      fail = 1'b1;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    phase_start_d = phase_start_q;
    accept_time_d = accept_time_q;
    sent_d        = sent_q;
    prep_only_d   = prep_only_q;
    run_mode_d    = run_mode_q;
    axis_set_d    = axis_set_q;
    cur_axis_d    = cur_axis_q;
    res_d         = '0;

    priority if (in_cmd_q == mass_pkg::CmdInit || in_cmd_q == mass_pkg::CmdPrepare) begin
      // start a new run
      accept_time_d = '0;
      prep_only_d   = (in_cmd_q == mass_pkg::CmdPrepare);
      run_mode_d    = start_mode;
      axis_set_d    = start_set;
      cur_axis_d    = start_axis;
      phase_start_d = now_ms;
      sent_d        = 1'b0;
      if (in_cmd_q == mass_pkg::CmdInit && !autostart_on_q) begin
        phase_d = mass_pkg::PhDisabled;
      end else begin
        phase_d = mass_pkg::PhWait;
      end
    end else if (in_cmd_q == mass_pkg::CmdCancel) begin
      if (run_busy) begin
        phase_d = mass_pkg::PhStopped;
      end
    end else if (in_cmd_q == mass_pkg::CmdReject) begin
      if (run_busy) begin
        phase_d = mass_pkg::PhFailed;
      end
    end else if (in_cmd_q == mass_pkg::CmdAccept) begin
      if (run_busy) begin
        sent_d        = 1'b1;
        accept_time_d = now_ms;
        phase_start_d = now_ms;
      end
    end else if (in_cmd_q == mass_pkg::CmdTick && run_busy) begin
      priority if (fail) begin
        phase_d = mass_pkg::PhFailed;
      end else if (phase_q == mass_pkg::PhWait) begin
        if ((healthy & axis_set_q) == axis_set_q) begin
          phase_d       = mass_pkg::PhEnable;
          phase_start_d = now_ms;
          sent_d        = 1'b0;
        end
      end else if (phase_q == mass_pkg::PhEnable) begin
        if (!sent_q) begin
          res_d.cmd_valid  = 1'b1;
          res_d.cmd_kind   = mass_pkg::KindEnable;
          res_d.cmd_enable = 1'b1;
        end else if (!pending && en_req && ready && flags_fresh) begin
          phase_d       = mass_pkg::PhZero;
          phase_start_d = now_ms;
          sent_d        = 1'b0;
        end
      end else if (phase_q == mass_pkg::PhZero) begin
        if (!sent_q && !(prep_only_q && orig_ok)) begin
          res_d.cmd_valid = 1'b1;
          res_d.cmd_kind  = mass_pkg::KindOrigin;
        end else if (zero_quick || zero_full) begin
          // advance to the next axis, or finish the set
          phase_start_d = now_ms;
          sent_d        = 1'b0;
          if (nx_found) begin
            cur_axis_d = nx_axis;
            phase_d    = mass_pkg::PhEnable;
          end else begin
            phase_d = prep_only_q ? mass_pkg::PhDone : mass_pkg::PhAction;
          end
        end
      end else begin
        if (!sent_q) begin
          res_d.cmd_valid = 1'b1;
          res_d.cmd_kind  = mass_pkg::KindAction;
          res_d.cmd_mode  = run_mode_q;
        end else if (act == mass_pkg::ActDone) begin
          phase_d = mass_pkg::PhDone;
        end else if (act[1]) begin
          phase_d = mass_pkg::PhFailed;
        end
      end
    end else begin
      // drop unknown codes and idle ticks
      phase_d = phase_q;
    end

    if (res_d.cmd_valid) begin
      res_d.cmd_axis = cur_axis_q;
    end
    res_d.phase = mass_pkg::phase_code(phase_d);
    res_d.busy  = (phase_d == mass_pkg::PhWait) || (phase_d == mass_pkg::PhEnable) ||
                  (phase_d == mass_pkg::PhZero) || (phase_d == mass_pkg::PhAction);
  end

  // Commit state when the word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= mass_pkg::PhDisabled;
      phase_start_q <= '0;
      accept_time_q <= '0;
      sent_q        <= 1'b0;
      prep_only_q   <= 1'b0;
      run_mode_q    <= '0;
      axis_set_q    <= '0;
      cur_axis_q    <= '0;
    end else if (advance) begin
      phase_q       <= phase_d;
      phase_start_q <= phase_start_d;
      accept_time_q <= accept_time_d;
      sent_q        <= sent_d;
      prep_only_q   <= prep_only_d;
      run_mode_q    <= run_mode_d;
      axis_set_q    <= axis_set_d;
      cur_axis_q    <= cur_axis_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q};

`ifndef NO_ASSERTIONS
  // A motor command is only issued from the enable, zero or action phase
  a_cmd_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.cmd_valid) |->
      (res_q.phase == mass_pkg::phase_code(mass_pkg::PhEnable) ||
       res_q.phase == mass_pkg::phase_code(mass_pkg::PhZero) ||
       res_q.phase == mass_pkg::phase_code(mass_pkg::PhAction)))
    else $error("command issued outside enable, zero or action phase");

  // Busy flag agrees with the reported phase
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_q.busy ==
      (res_q.phase >= mass_pkg::phase_code(mass_pkg::PhWait) &&
       res_q.phase <= mass_pkg::phase_code(mass_pkg::PhAction))))
    else $error("busy flag disagrees with phase");

  // A held input word is never overwritten before it is processed
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !s_axis_tready)
    else $error("input register overrun");

  // State changes only when a word is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(phase_q))
    else $error("phase changed without a word");
`endif

endmodule

>>> tb/multi_axis_startup_sequencer_unit_tb.sv
// Self-checking testbench for the multi-axis startup sequencer unit.
module multi_axis_startup_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 600000;
  localparam int DrainCycles  = 8;
  localparam int RandomItems  = 1400;
  localparam int NumSettings  = 7;
  localparam int ScriptRows   = 25;
  localparam int MaxPrinted   = 100;

  // Item codes the block must ignore
  localparam logic [mass_pkg::CmdWidth-1:0] CmdSpareA = 3'd6;
  localparam logic [mass_pkg::CmdWidth-1:0] CmdSpareB = 3'd7;

  // Mode code outside the listed modes
  localparam logic [mass_pkg::ModeWidth-1:0] ModeSpare = 2'd3;

  // Action status codes beside ActDone
  localparam logic [mass_pkg::ActWidth-1:0] ActRunning = 2'd0;
  localparam logic [mass_pkg::ActWidth-1:0] ActAborted = 2'd3;

  // Axis masks; an index beyond the mask adds no axis
  localparam logic [mass_pkg::MaskWidth-1:0] ZBit =
    (mass_pkg::ZIndex < mass_pkg::AxisLimit) ?
      mass_pkg::MaskWidth'(1 << mass_pkg::ZIndex) : '0;
  localparam logic [mass_pkg::MaskWidth-1:0] XBit =
    (mass_pkg::XIndex < mass_pkg::AxisLimit) ?
      mass_pkg::MaskWidth'(1 << mass_pkg::XIndex) : '0;
  localparam logic [mass_pkg::MaskWidth-1:0] YawBit =
    (mass_pkg::YawIndex < mass_pkg::AxisLimit) ?
      mass_pkg::MaskWidth'(1 << mass_pkg::YawIndex) : '0;
  localparam logic [mass_pkg::MaskWidth-1:0] AllAxes = '1;

  // Axis status patterns
  localparam logic [mass_pkg::MaskWidth-1:0] StEnabledBits =
    mass_pkg::MaskWidth'((1 << mass_pkg::StEnReq) | (1 << mass_pkg::StReady));
  localparam logic [mass_pkg::MaskWidth-1:0] StZeroedBits  =
    StEnabledBits | mass_pkg::MaskWidth'(1 << mass_pkg::StOrigin);

  // External phase codes
  typedef enum logic [mass_pkg::PhaseWidth-1:0] {
    SeqDisabled, SeqWait, SeqEnable, SeqZero, SeqAction, SeqDone, SeqFailed, SeqStopped
  } seq_phase_e;

  // Input word layout, first field in the lowest bits
  typedef struct packed {
    logic [6:0]                     pad;
    logic [mass_pkg::ActWidth-1:0]  act;
    logic                           at_origin;
    logic [mass_pkg::TimeWidth-1:0] pos_t;
    logic [mass_pkg::TimeWidth-1:0] flags_t;
    logic [mass_pkg::MaskWidth-1:0] status;
    logic [mass_pkg::MaskWidth-1:0] healthy;
    logic [mass_pkg::MaskWidth-1:0] faults;
    logic [mass_pkg::ModeWidth-1:0] mode;
    logic [mass_pkg::TimeWidth-1:0] now;
  } sensor_word_t;

  typedef struct {
    logic [mass_pkg::CmdWidth-1:0]  cmd;
    logic [mass_pkg::TimeWidth-1:0] now;
    logic [mass_pkg::ModeWidth-1:0] mode;
    logic [mass_pkg::MaskWidth-1:0] faults;
    logic [mass_pkg::MaskWidth-1:0] healthy;
    logic [mass_pkg::MaskWidth-1:0] status;
    logic [mass_pkg::TimeWidth-1:0] flags_t;
    logic [mass_pkg::TimeWidth-1:0] pos_t;
    logic                           at_origin;
    logic [mass_pkg::ActWidth-1:0]  act;
    bit                             typed;
    seq_phase_e                     exp_phase;
    bit                             exp_busy;
  } script_row_t;

  typedef struct {
    logic                              on;
    logic [mass_pkg::ModeWidth-1:0]    mode;
    logic [mass_pkg::TimeoutWidth-1:0] timeout;
  } setting_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [1:0]   cfg_index_i;
  logic [19:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;

  multi_axis_startup_sequencer_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Predictor state and configuration copy
  seq_phase_e                        seq_phase;
  logic [mass_pkg::TimeWidth-1:0]    phase_t0;
  logic [mass_pkg::TimeWidth-1:0]    accept_t;
  logic                              cmd_sent;
  logic                              prep_run;
  logic [mass_pkg::ModeWidth-1:0]    run_mode_q;
  logic [mass_pkg::MaskWidth-1:0]    active_axes;
  logic [mass_pkg::AxisWidth-1:0]    axis_sel;
  logic                              cfg_autostart;
  logic [mass_pkg::ModeWidth-1:0]    cfg_mode;
  logic [mass_pkg::TimeoutWidth-1:0] cfg_timeout;

  mass_pkg::result_t expected_reports [$];
  int                mismatch_count = 0;
  int unsigned       cycle_count = 0;
  int                calm_left = 0;
  bit                last_cmd_valid = 1'b0;

  // Directed walk: idle handling, one full press run, failures, cancel and wrap
  script_row_t startup_script [ScriptRows] = '{
    '{mass_pkg::CmdTick, 32'd0, mass_pkg::ModePress, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0, 1'b0,
      ActRunning, 1'b1, SeqDisabled, 1'b0},
    '{CmdSpareA, 32'd10, mass_pkg::ModeRub, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0, 1'b0,
      ActRunning, 1'b1, SeqDisabled, 1'b0},
    '{CmdSpareB, 32'hFFFF_FFFF, ModeSpare, AllAxes, AllAxes, 4'hF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 1'b1, ActAborted, 1'b1, SeqDisabled, 1'b0},
    '{mass_pkg::CmdInit, 32'd100, mass_pkg::ModeSlide, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqWait, 1'b1},
    '{mass_pkg::CmdTick, 32'd150, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqEnable, 1'b1},
    '{mass_pkg::CmdTick, 32'd160, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdAccept, 32'd300, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdTick, 32'd310, mass_pkg::ModePress, 4'd0, AllAxes, StEnabledBits, 32'd301,
      32'd0, 1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdTick, 32'd320, mass_pkg::ModePress, 4'd0, AllAxes, StEnabledBits, 32'd301,
      32'd0, 1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdAccept, 32'd400, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdTick, 32'd420, mass_pkg::ModePress, 4'd0, AllAxes, StZeroedBits, 32'd401,
      32'd402, 1'b1, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdTick, 32'd430, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdAccept, 32'd500, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdTick, 32'd510, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, mass_pkg::ActDone, 1'b1, SeqDone, 1'b0},
    '{mass_pkg::CmdPrepare, 32'd1000, ModeSpare, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0, 1'b0,
      ActRunning, 1'b1, SeqWait, 1'b1},
    '{mass_pkg::CmdTick, 32'd1001, mass_pkg::ModePress, AllAxes, AllAxes, 4'd0, 32'd0,
      32'd0, 1'b0, ActRunning, 1'b1, SeqFailed, 1'b0},
    '{mass_pkg::CmdPrepare, 32'd2000, mass_pkg::ModeRub, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqWait, 1'b1},
    '{mass_pkg::CmdCancel, 32'd2001, mass_pkg::ModePress, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqStopped, 1'b0},
    '{mass_pkg::CmdCancel, 32'd2002, mass_pkg::ModePress, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqStopped, 1'b0},
    '{mass_pkg::CmdPrepare, 32'd5000, mass_pkg::ModeSlide, 4'd0, 4'd0, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqWait, 1'b1},
    '{mass_pkg::CmdTick, 32'd7000, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0, 32'd0,
      1'b0, ActRunning, 1'b1, SeqFailed, 1'b0},
    '{mass_pkg::CmdPrepare, 32'hFFFF_FF00, mass_pkg::ModeSlide, 4'd0, 4'd0, 4'd0, 32'd0,
      32'd0, 1'b0, ActRunning, 1'b1, SeqWait, 1'b1},
    '{mass_pkg::CmdTick, 32'h0000_0100, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0,
      32'd0, 1'b0, ActRunning, 1'b1, SeqEnable, 1'b1},
    '{mass_pkg::CmdTick, 32'h0000_0110, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0,
      32'd0, 1'b0, ActRunning, 1'b0, SeqDisabled, 1'b0},
    '{mass_pkg::CmdReject, 32'h0000_0120, mass_pkg::ModePress, 4'd0, AllAxes, 4'd0, 32'd0,
      32'd0, 1'b0, ActRunning, 1'b1, SeqFailed, 1'b0}
  };

  // Register settings walked by the random part; the first one is the reset state
  setting_t run_settings [NumSettings] = '{
    '{1'b1, mass_pkg::ModePress, 20'd2000},
    '{1'b1, mass_pkg::ModeRub,   20'd1000000},
    '{1'b0, mass_pkg::ModeSlide, 20'd1},
    '{1'b1, mass_pkg::ModeSlide, 20'hFFFFF},
    '{1'b1, mass_pkg::ModePress, 20'd0},
    '{1'b1, mass_pkg::ModeRub,   20'd40},
    '{1'b1, mass_pkg::ModeSlide, 20'd2000}
  };

  function automatic bit run_busy();
    return seq_phase >= SeqWait && seq_phase <= SeqAction;
  endfunction

  // A time is fresh when it lies strictly after the last accept, signed wrap
  function automatic bit is_fresh(input logic [mass_pkg::TimeWidth-1:0] t);
    logic [mass_pkg::TimeWidth-1:0] d;
    d = t - accept_t;
    return d != '0 && !d[mass_pkg::TimeWidth-1];
  endfunction

  function automatic void enter_phase(input seq_phase_e ph,
                                      input logic [mass_pkg::TimeWidth-1:0] now);
    seq_phase = ph;
    phase_t0  = now;
    cmd_sent  = 1'b0;
  endfunction

  // Load the axis set for a mode and point at its lowest axis
  function automatic void begin_run(input logic [mass_pkg::ModeWidth-1:0] mode,
                                    input logic prep, input seq_phase_e ph,
                                    input logic [mass_pkg::TimeWidth-1:0] now);
    accept_t    = '0;
    prep_run    = prep;
    run_mode_q  = mode;
    active_axes = ZBit;
    if (mode == mass_pkg::ModeRub) begin
      active_axes |= YawBit;
    end else if (mode == mass_pkg::ModeSlide) begin
      active_axes |= XBit;
    end
    axis_sel = '0;
    for (int i = mass_pkg::AxisLimit - 1; i >= 0; i--) begin
      if (active_axes[i]) axis_sel = mass_pkg::AxisWidth'(i);
    end
    enter_phase(ph, now);
  endfunction

  // Advance the sequencer by one word and return its report
  function automatic mass_pkg::result_t sequencer_step(
      input logic [mass_pkg::CmdWidth-1:0] cmd, input sensor_word_t w);
    mass_pkg::result_t              r;
    seq_phase_e                     start_ph;
    logic [mass_pkg::MaskWidth-1:0] down_ok;
    logic [mass_pkg::TimeWidth-1:0] elapsed;
    logic                           failed;
    logic                           base;
    logic                           quick;
    logic                           full;
    int                             nx;
    r       = '0;
    elapsed = w.now - phase_t0;
    case (cmd)
      mass_pkg::CmdInit: begin
        if (cfg_autostart) start_ph = SeqWait;
        else start_ph = SeqDisabled;
        begin_run(cfg_mode, 1'b0, start_ph, w.now);
      end
      mass_pkg::CmdPrepare: begin
        begin_run(w.mode, 1'b1, SeqWait, w.now);
      end
      mass_pkg::CmdCancel: begin
        if (run_busy()) seq_phase = SeqStopped;
      end
      mass_pkg::CmdReject: begin
        if (run_busy()) seq_phase = SeqFailed;
      end
      mass_pkg::CmdAccept: begin
        if (run_busy()) begin
          cmd_sent = 1'b1;
          accept_t = w.now;
          phase_t0 = w.now;
        end
      end
      mass_pkg::CmdTick: begin
        if (run_busy()) begin
          // Fail on timeout, a faulty axis or a lost axis
          failed = 1'b0;
          if (seq_phase != SeqAction && elapsed >= mass_pkg::TimeWidth'(cfg_timeout)) begin
            failed = 1'b1;
          end
          if ((w.faults & active_axes) != '0) failed = 1'b1;
          if (seq_phase != SeqWait) begin
            down_ok = (seq_phase == SeqZero) ? (mass_pkg::MaskWidth'(1) << axis_sel) : '0;
            if ((~w.healthy & active_axes & ~down_ok) != '0) failed = 1'b1;
          end
          if (failed) begin
            seq_phase = SeqFailed;
          end else begin
            case (seq_phase)
              SeqWait: begin
                if ((w.healthy & active_axes) == active_axes) enter_phase(SeqEnable, w.now);
              end
              SeqEnable: begin
                if (!cmd_sent) begin
                  r.cmd_valid  = 1'b1;
                  r.cmd_kind   = mass_pkg::KindEnable;
                  r.cmd_enable = 1'b1;
                end else if (!w.status[mass_pkg::StPending] && w.status[mass_pkg::StEnReq] &&
                             w.status[mass_pkg::StReady] && is_fresh(w.flags_t)) begin
                  enter_phase(SeqZero, w.now);
                end
              end
              SeqZero: begin
                if (!cmd_sent && !(prep_run && w.status[mass_pkg::StOrigin])) begin
                  r.cmd_valid = 1'b1;
                  r.cmd_kind  = mass_pkg::KindOrigin;
                end else begin
                  base  = w.healthy[axis_sel] && !w.status[mass_pkg::StPending] &&
                          w.status[mass_pkg::StOrigin] && w.status[mass_pkg::StEnReq] &&
                          w.status[mass_pkg::StReady];
                  quick = base && prep_run && !cmd_sent;
                  full  = base && is_fresh(w.pos_t) && is_fresh(w.flags_t) && w.at_origin;
                  // Move on to the next axis of the set, or finish the setup
                  if (quick || full) begin
                    nx = int'(axis_sel) + 1;
                    while (nx < mass_pkg::AxisLimit && !active_axes[nx]) nx++;
                    if (nx < mass_pkg::AxisLimit) begin
                      axis_sel = mass_pkg::AxisWidth'(nx);
                      enter_phase(SeqEnable, w.now);
                    end else if (prep_run) begin
                      enter_phase(SeqDone, w.now);
                    end else begin
                      enter_phase(SeqAction, w.now);
                    end
                  end
                end
              end
              default: begin
                if (!cmd_sent) begin
                  r.cmd_valid = 1'b1;
                  r.cmd_kind  = mass_pkg::KindAction;
                  r.cmd_mode  = run_mode_q;
                end else if (w.act == mass_pkg::ActDone) begin
                  seq_phase = SeqDone;
                end else if (w.act != ActRunning) begin
                  seq_phase = SeqFailed;
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    r.cmd_axis = r.cmd_valid ? axis_sel : '0;
    r.phase    = seq_phase;
    r.busy     = run_busy();
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s: got %0d, want %0d", name, got, want));
  endtask

  // Offer one word, wait for the handshake, record its report, then idle a while
  task automatic send_item(input logic [mass_pkg::CmdWidth-1:0] cmd, input sensor_word_t w,
                           input bit typed, input mass_pkg::result_t typed_report);
    mass_pkg::result_t r;
    int                gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = sequencer_step(cmd, w);
    last_cmd_valid = r.cmd_valid;
    expected_reports.push_back(typed ? typed_report : r);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 80);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [19:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      mass_pkg::CfgAutostartOn:   cfg_autostart = value[0];
      mass_pkg::CfgAutostartMode: cfg_mode      = value[mass_pkg::ModeWidth-1:0];
      mass_pkg::CfgSetupTimeout:  cfg_timeout   = value;
      default: ;
    endcase
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Give up on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("multi_axis_startup_sequencer_unit: mismatch");
      $finish;
    end
  end

  // Result side back-pressure: short bursts, occasional long free runs
  initial begin
    int burst;
    int stall;
    m_axis_tready = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) burst = $urandom_range(50, 200);
      else burst = $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Compare each report word with the oldest expectation
  always @(posedge clk_i) begin
    mass_pkg::result_t got;
    mass_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mass_pkg::result_t'(m_axis_tdata[$bits(mass_pkg::result_t)-1:0]);
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("report word %h with nothing expected", got));
      end else begin
        want = expected_reports.pop_front();
        check_field("cmd_valid", got.cmd_valid, want.cmd_valid);
        check_field("cmd_kind", got.cmd_kind, want.cmd_kind);
        check_field("cmd_axis", got.cmd_axis, want.cmd_axis);
        check_field("cmd_enable", got.cmd_enable, want.cmd_enable);
        check_field("cmd_mode", got.cmd_mode, want.cmd_mode);
        check_field("phase", got.phase, want.phase);
        check_field("busy", got.busy, want.busy);
      end
    end
  end

  // Stimulus
  initial begin
    sensor_word_t                   w;
    mass_pkg::result_t              typed_report;
    logic [mass_pkg::CmdWidth-1:0]  cmd;
    logic [mass_pkg::TimeWidth-1:0] t_now;
    int                             active_items;
    int                             pick;
    int                             target;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;

    // State after reset
    seq_phase     = SeqDisabled;
    phase_t0      = '0;
    accept_t      = '0;
    cmd_sent      = 1'b0;
    prep_run      = 1'b0;
    run_mode_q    = '0;
    active_axes   = '0;
    axis_sel      = '0;
    cfg_autostart = 1'b1;
    cfg_mode      = mass_pkg::ModePress;
    cfg_timeout   = 20'd2000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed script
    foreach (startup_script[i]) begin
      w              = '0;
      w.now          = startup_script[i].now;
      w.mode         = startup_script[i].mode;
      w.faults       = startup_script[i].faults;
      w.healthy      = startup_script[i].healthy;
      w.status       = startup_script[i].status;
      w.flags_t      = startup_script[i].flags_t;
      w.pos_t        = startup_script[i].pos_t;
      w.at_origin    = startup_script[i].at_origin;
      w.act          = startup_script[i].act;
      typed_report       = '0;
      typed_report.phase = startup_script[i].exp_phase;
      typed_report.busy  = startup_script[i].exp_busy;
      send_item(startup_script[i].cmd, w, startup_script[i].typed, typed_report);
    end

    // Random runs under each register setting
    t_now        = 32'h0001_0000;
    active_items = 0;
    for (int p = 0; p < NumSettings; p++) begin
      if (p > 0) begin
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk_i);
        repeat (DrainCycles) @(posedge clk_i);
        write_register(mass_pkg::CfgAutostartOn, 20'(run_settings[p].on));
        write_register(mass_pkg::CfgAutostartMode, 20'(run_settings[p].mode));
        write_register(mass_pkg::CfgSetupTimeout, run_settings[p].timeout);
        cfg_we_i <= 1'b0;
      end
      target = (p + 1) * RandomItems / NumSettings;
      while (active_items < target) begin
        // Choose the item from where the run stands: start, answer or tick
        pick = $urandom_range(0, 99);
        if (!run_busy()) begin
          if (pick < 45) cmd = mass_pkg::CmdInit;
          else if (pick < 88) cmd = mass_pkg::CmdPrepare;
          else if (pick < 92) cmd = $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
          else cmd = mass_pkg::CmdWidth'($urandom_range(0, 5));
          if ($urandom_range(0, 9) == 0) t_now = $urandom();
        end else if (last_cmd_valid) begin
          if (pick < 88) cmd = mass_pkg::CmdAccept;
          else if (pick < 91) cmd = mass_pkg::CmdReject;
          else cmd = mass_pkg::CmdTick;
        end else begin
          if (pick < 93) cmd = mass_pkg::CmdTick;
          else if (pick < 94) cmd = mass_pkg::CmdCancel;
          else if (pick < 95) cmd = mass_pkg::CmdInit;
          else if (pick < 96) cmd = mass_pkg::CmdPrepare;
          else if (pick < 98) cmd = mass_pkg::CmdAccept;
          else if (pick < 99) cmd = mass_pkg::CmdReject;
          else cmd = $urandom_range(0, 1) ? CmdSpareA : CmdSpareB;
        end
        if (run_busy() || cmd == mass_pkg::CmdInit || cmd == mass_pkg::CmdPrepare) begin
          active_items++;
        end

        // Advance time, now and then by a jump around the timeout
        pick = $urandom_range(0, 99);
        if (pick >= 25 && pick < 97) t_now += 32'($urandom_range(1, 30));
        else if (pick >= 97) t_now += 32'($urandom_range(0, 2 * int'(cfg_timeout) + 64));

        // Mostly a cooperative motor set, with faults and stale data mixed in
        w         = '0;
        w.now     = t_now;
        w.mode    = ($urandom_range(0, 9) == 0) ? ModeSpare
                                                : mass_pkg::ModeWidth'($urandom_range(0, 2));
        w.faults  = ($urandom_range(0, 49) == 0) ? mass_pkg::MaskWidth'($urandom_range(1, 15))
                                                 : '0;
        w.healthy = ($urandom_range(0, 24) == 0) ? mass_pkg::MaskWidth'($urandom_range(0, 15))
                                                 : AllAxes;
        pick = $urandom_range(0, 99);
        if (pick < 10) w.status = mass_pkg::MaskWidth'($urandom_range(0, 15));
        else if (pick < 25) w.status = StEnabledBits;
        else w.status = StZeroedBits;
        w.flags_t = ($urandom_range(0, 9) == 0) ? $urandom()
                                                : accept_t + 32'($urandom_range(0, 100));
        w.pos_t   = ($urandom_range(0, 9) == 0) ? $urandom()
                                                : accept_t + 32'($urandom_range(0, 100));
        w.at_origin = $urandom_range(0, 9) != 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) w.act = ActRunning;
        else if (pick < 85) w.act = mass_pkg::ActDone;
        else w.act = mass_pkg::ActWidth'($urandom_range(2, 3));
        send_item(cmd, w, 1'b0, '0);
      end
    end

    // Drain and conclude
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("multi_axis_startup_sequencer_unit: match");
    end else begin
      $display("multi_axis_startup_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule
